[sv/tcw_pkg.sv]
// tcw_pkg: shared types, codes and screen geometry for the text console writer
// used by every module of the block; depends on nothing
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int CUR_W   = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);

  // command queue between front and back
  localparam int Q_DEPTH = 2;

  // request op codes
  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_SETPOS = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // special characters
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // configuration register indexes
  localparam logic [1:0] REG_ATTRIBUTE  = 2'd0;
  localparam logic [1:0] REG_BLANK_CELL = 2'd1;
  localparam logic [1:0] REG_TAB_WIDTH  = 2'd2;

  // configuration reset values
  localparam logic [7:0]  ATTRIBUTE_RESET  = 8'd7;
  localparam logic [15:0] BLANK_CELL_RESET = 16'd1824;
  localparam logic [3:0]  TAB_WIDTH_RESET  = 4'd8;

  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_NEWLINE,
    CMD_TAB,
    CMD_CLEAR,
    CMD_SETPOS,
    CMD_READ
  } cmd_kind_t;

  // classified request as it sits in the queue
  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       ch;
    logic             on_screen;
    logic [CUR_W-1:0] addr;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  attribute;
    logic [15:0] blank_cell;
    logic [3:0]  tab_width;
  } cfg_t;

  typedef struct packed {
    logic [10:0] cursor_index;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        scrolled;
    logic        range_error;
    logic [15:0] cell_data;
  } res_t;

endpackage

`default_nettype wire

[sv/tcw_front.sv]
// tcw_front: classifies an incoming request and forms its cell address
// depends on tcw_pkg
`default_nettype none

module tcw_front
  import tcw_pkg::*;
(
  input  wire logic [1:0] op,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] col,
  input  wire logic [7:0] row,
  output cmd_t            cmd
);

  logic [15:0] lin;
  logic        on_screen;

  // position check and linear cell address
  assign on_screen = (col < 8'(COLUMNS)) && (row < 8'(ROWS));
  assign lin       = 16'(row) * 16'(COLUMNS) + 16'(col);

  // request classification
  always_comb begin
    cmd.ch        = char_code;
    cmd.on_screen = on_screen;
    cmd.addr      = CUR_W'(lin);
    cmd.col       = COL_W'(col);
    cmd.row       = ROW_W'(row);
    case (op)
      OP_PUT: begin
        if (char_code == CH_NEWLINE) cmd.kind = CMD_NEWLINE;
        else if (char_code == CH_TAB) cmd.kind = CMD_TAB;
        else cmd.kind = CMD_CHAR;
      end
      OP_CLEAR:  cmd.kind = CMD_CLEAR;
      OP_SETPOS: cmd.kind = CMD_SETPOS;
      OP_READ:   cmd.kind = CMD_READ;
      default:   cmd.kind = CMD_CHAR;
    endcase
  end

endmodule

`default_nettype wire

[sv/tcw_cmd_queue.sv]
// tcw_cmd_queue: short queue of classified requests between front and back
// depends on tcw_pkg
`default_nettype none

module tcw_cmd_queue
  import tcw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  cmd_t      wr_cmd,
  output logic      q_full,
  input  wire logic rd_en,
  output logic      q_valid,
  output cmd_t      q_head
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             slots [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_full  = (count == CNT_W'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_cmd;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

[sv/tcw_back.sv]
// tcw_back: cursor, screen memory, scroll and fill sweeps, result register
// depends on tcw_pkg
`default_nettype none

module tcw_back
  import tcw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  wire logic q_valid,
  input  cmd_t      q_head,
  output logic      q_pop,
  input  wire logic out_pop,
  output logic      out_valid,
  output res_t      res,
  output logic      init_busy
);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_STEP   = 7'b0000100,
    S_READ   = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  localparam logic [CUR_W-1:0] LAST_CELL = CUR_W'(CELLS - 1);
  localparam logic [CUR_W-1:0] LAST_ROW0 = CUR_W'(CELLS - COLUMNS);

  state_t           state;
  logic [CUR_W-1:0] cur_idx;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [3:0]       step_cnt;
  logic [CUR_W-1:0] rd_ptr;
  logic             copy_valid;
  logic [CUR_W-1:0] copy_dst;
  logic [CUR_W-1:0] fill_ptr;
  logic [15:0]      fill_val;
  logic             res_scrolled;
  logic             res_range;
  logic [15:0]      res_data;

  logic [15:0]      mem [CELLS];
  logic [15:0]      rdata;
  logic             we;
  logic [CUR_W-1:0] waddr;
  logic [15:0]      wdata;
  logic [CUR_W-1:0] raddr;

  logic [CUR_W-1:0] adv_idx;
  logic [COL_W-1:0] adv_col;
  logic [ROW_W-1:0] adv_row;
  logic             adv_ovf;
  logic [CUR_W-1:0] nl_idx;
  logic             nl_ovf;
  logic             out_free;
  logic             filling;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign init_busy = (state == S_INIT);
  assign out_free  = !out_valid || out_pop;
  assign filling   = (state == S_FILL) || (state == S_INIT);

  // one-cell cursor advance and newline target
  always_comb begin
    adv_ovf = (cur_idx == LAST_CELL);
    adv_idx = cur_idx + 1'b1;
    if (cur_col == COL_W'(COLUMNS - 1)) begin
      adv_col = '0;
      adv_row = cur_row + 1'b1;
    end else begin
      adv_col = cur_col + 1'b1;
      adv_row = cur_row;
    end
    nl_idx = cur_idx + CUR_W'(COLUMNS) - CUR_W'(cur_col);
    nl_ovf = (cur_row == ROW_W'(ROWS - 1));
  end

  // memory write select: scroll copy, then fill, then character store
  always_comb begin
    we    = 1'b0;
    waddr = cur_idx;
    wdata = {cfg.attribute, q_head.ch};
    if (copy_valid) begin
      we    = 1'b1;
      waddr = copy_dst;
      wdata = rdata;
    end else if (filling) begin
      we    = 1'b1;
      waddr = fill_ptr;
      wdata = fill_val;
    end else if (q_pop && (q_head.kind == CMD_CHAR)) begin
      we    = 1'b1;
    end
  end

  assign raddr = (state == S_SCROLL) ? rd_ptr : q_head.addr;

  // screen memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      cur_idx      <= '0;
      cur_col      <= '0;
      cur_row      <= '0;
      step_cnt     <= '0;
      rd_ptr       <= '0;
      copy_valid   <= 1'b0;
      copy_dst     <= '0;
      fill_ptr     <= '0;
      fill_val     <= BLANK_CELL_RESET;
      res_scrolled <= 1'b0;
      res_range    <= 1'b0;
      res_data     <= '0;
    end else begin
      copy_valid <= (state == S_SCROLL);
      copy_dst   <= rd_ptr - CUR_W'(COLUMNS);
      case (state)
        S_INIT: begin
          fill_ptr <= fill_ptr + 1'b1;
          if (fill_ptr == LAST_CELL) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            res_scrolled <= 1'b0;
            res_range    <= 1'b0;
            res_data     <= '0;
            state        <= S_DONE;
            case (q_head.kind)
              CMD_CHAR: begin
                if (adv_ovf) begin
                  state <= S_SCROLL;
                end else begin
                  cur_idx <= adv_idx;
                  cur_col <= adv_col;
                  cur_row <= adv_row;
                end
              end
              CMD_NEWLINE: begin
                if (nl_ovf) begin
                  state <= S_SCROLL;
                end else begin
                  cur_idx <= nl_idx;
                  cur_col <= '0;
                  cur_row <= cur_row + 1'b1;
                end
              end
              CMD_TAB: begin
                step_cnt <= cfg.tab_width;
                if (cfg.tab_width != '0) state <= S_STEP;
              end
              CMD_CLEAR: begin
                cur_idx  <= '0;
                cur_col  <= '0;
                cur_row  <= '0;
                fill_ptr <= '0;
                fill_val <= cfg.blank_cell;
                state    <= S_FILL;
              end
              CMD_SETPOS: begin
                if (q_head.on_screen) begin
                  cur_idx <= q_head.addr;
                  cur_col <= q_head.col;
                  cur_row <= q_head.row;
                end else begin
                  res_range <= 1'b1;
                end
              end
              CMD_READ: begin
                if (q_head.on_screen) state <= S_READ;
                else res_range <= 1'b1;
              end
              default: state <= S_DONE;
            endcase
            // overrun: cursor to the last row, start the copy sweep
            if (((q_head.kind == CMD_CHAR) && adv_ovf) ||
                ((q_head.kind == CMD_NEWLINE) && nl_ovf)) begin
              cur_idx      <= LAST_ROW0;
              cur_col      <= '0;
              cur_row      <= ROW_W'(ROWS - 1);
              res_scrolled <= 1'b1;
              rd_ptr       <= CUR_W'(COLUMNS);
              fill_ptr     <= LAST_ROW0;
              fill_val     <= {cfg.attribute, CH_SPACE};
            end
          end
        end
        S_STEP: begin
          if (adv_ovf) begin
            cur_idx      <= LAST_ROW0;
            cur_col      <= '0;
            cur_row      <= ROW_W'(ROWS - 1);
            res_scrolled <= 1'b1;
            rd_ptr       <= CUR_W'(COLUMNS);
            fill_ptr     <= LAST_ROW0;
            fill_val     <= {cfg.attribute, CH_SPACE};
            state        <= S_SCROLL;
          end else begin
            cur_idx  <= adv_idx;
            cur_col  <= adv_col;
            cur_row  <= adv_row;
            step_cnt <= step_cnt - 1'b1;
            if (step_cnt == 4'd1) state <= S_DONE;
          end
        end
        S_READ: begin
          res_data <= rdata;
          state    <= S_DONE;
        end
        S_SCROLL: begin
          rd_ptr <= rd_ptr + 1'b1;
          if (rd_ptr == LAST_CELL) state <= S_FILL;
        end
        S_FILL: begin
          // hold while the last copy write drains
          if (!copy_valid) begin
            fill_ptr <= fill_ptr + 1'b1;
            if (fill_ptr == LAST_CELL) state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      res.cursor_index <= 11'(cur_idx);
      res.cursor_col   <= 7'(cur_col);
      res.cursor_row   <= 5'(cur_row);
      res.scrolled     <= res_scrolled;
      res.range_error  <= res_range;
      res.cell_data    <= res_data;
    end
  end

  // copy writes never reach the last row
  a_copy_dst: assert property (@(posedge clk) disable iff (rst)
    copy_valid |-> (copy_dst < LAST_ROW0))
    else $error("scroll copy wrote into the last row");

  // index, column and row describe the same cell
  a_cursor_consistent: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_idx) == 32'(cur_row) * COLUMNS + 32'(cur_col)))
    else $error("cursor index disagrees with column and row");

  // a result only appears at the end of an item
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the done state");

  // the copy sweep only runs for a scrolling item
  a_scroll_flag: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL) |-> res_scrolled)
    else $error("scroll sweep without scroll flag");

endmodule

`default_nettype wire

[sv/text_console_char_writer.sv]
// text_console_char_writer: text console top level with config registers
// a request passes the queue, then the back's idle and done states, then the result register
// the back takes one request at a time; a tab steps the cursor tab_width cells; a clear fills
// every cell; a scroll runs a copy sweep, then a last-row fill; a held result stalls the back
// reset: synchronous; a blanking pass writes one cell per cycle, no requests taken
// depends on tcw_pkg, tcw_front, tcw_cmd_queue, tcw_back
`default_nettype none

module text_console_char_writer
  import tcw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  char_code,
  input  wire logic [7:0]  col,
  input  wire logic [7:0]  row,
  output logic             empty,
  input  wire logic        pop,
  output logic [10:0]      cursor_index,
  output logic [6:0]       cursor_col,
  output logic [4:0]       cursor_row,
  output logic             scrolled,
  output logic             range_error,
  output logic [15:0]      cell_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cmd_t cmd;
  cmd_t q_head;
  cfg_t cfg;
  res_t res;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic out_valid;
  logic init_busy;
  logic in_take;
  logic out_take;

  assign full      = q_full || init_busy;
  assign in_take   = push && !full;
  assign empty     = !out_valid;
  assign out_take  = pop && out_valid;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attribute  <= ATTRIBUTE_RESET;
      cfg.blank_cell <= BLANK_CELL_RESET;
      cfg.tab_width  <= TAB_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ATTRIBUTE:  cfg.attribute  <= cfg_data[7:0];
        REG_BLANK_CELL: cfg.blank_cell <= cfg_data;
        REG_TAB_WIDTH:  cfg.tab_width  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  tcw_front u_front (
    .op        (op),
    .char_code (char_code),
    .col       (col),
    .row       (row),
    .cmd       (cmd)
  );

  tcw_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_take),
    .wr_cmd  (cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_take),
    .out_valid (out_valid),
    .res       (res),
    .init_busy (init_busy)
  );

  // result fields
  assign cursor_index = res.cursor_index;
  assign cursor_col   = res.cursor_col;
  assign cursor_row   = res.cursor_row;
  assign scrolled     = res.scrolled;
  assign range_error  = res.range_error;
  assign cell_data    = res.cell_data;

endmodule

`default_nettype wire
